@@ design/wndc_pkg.sv @@
// ----------------------------------------------------------------------------
// wndc_pkg
// Shared types, sizes and helpers for the sliding window distinct counter.
// ----------------------------------------------------------------------------
package wndc_pkg;

    localparam int WINDOW_MAX  = 32;
    localparam int TOTAL_WIDTH = 16;
    localparam int ALPHABET    = 26;

    localparam int LETTER_W = 5;
    localparam int CFG_W    = 6;
    localparam int PTR_W    = $clog2(WINDOW_MAX);
    localparam int LEN_W    = $clog2(WINDOW_MAX + 1);
    localparam int COUNT_W  = LEN_W;
    localparam int EXT_W    = (CFG_W > LEN_W) ? CFG_W : LEN_W;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LETTER_W-1:0] LAST_LETTER       = LETTER_W'(ALPHABET - 1);
    localparam logic [CFG_W-1:0]    WINDOW_LEN_RESET  = CFG_W'(2);
    localparam logic                REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                first_of_string;
        logic                last_of_string;
    } t_item;

    typedef struct packed {
        logic                   window_full;
        logic                   window_matches;
        logic [TOTAL_WIDTH-1:0] match_total;
        logic                   string_done;
    } t_result;

    typedef struct packed {
        logic             clear;
        logic [LEN_W-1:0] window_len;
    } t_cfg_ctl;

    // Clamp the programmed length into 1..WINDOW_MAX.
    function automatic logic [LEN_W-1:0] eff_length(input logic [CFG_W-1:0] v);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (v == '0) begin
            return LEN_W'(1);
        end
        if (ext > EXT_W'(WINDOW_MAX)) begin
            return LEN_W'(WINDOW_MAX);
        end
        return LEN_W'(ext);
    endfunction

    function automatic logic [LETTER_W-1:0] clamp_letter(input logic [LETTER_W-1:0] v);
        return (v > LAST_LETTER) ? LAST_LETTER : v;
    endfunction

endpackage

@@ design/wndc_cfg.sv @@
// ----------------------------------------------------------------------------
// wndc_cfg
// APB register file: window length register and string clear strobe.
// ----------------------------------------------------------------------------
module wndc_cfg import wndc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg_ctl          o_ctl
);

    logic [CFG_W-1:0] r_window_length;
    logic             r_clear;
    logic             wr_len;

    assign pready = 1'b1;
    assign wr_len = psel & penable & pwrite & (paddr[2] == REG_WINDOW_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LEN_RESET;
            r_clear         <= 1'b0;
        end else begin
            r_clear <= wr_len;
            if (wr_len) begin
                r_window_length <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW_LENGTH) begin
            prdata = DATA_W'(r_window_length);
        end
    end

    // Length writes wipe string state; user writes only while idle, unchecked.
    assign o_ctl.clear      = r_clear;
    assign o_ctl.window_len = eff_length(r_window_length);

endmodule

@@ design/wndc_front.sv @@
// ----------------------------------------------------------------------------
// wndc_front
// Accepts letters, clamps the code and queues items for the window engine.
// ----------------------------------------------------------------------------
module wndc_front import wndc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [LETTER_W-1:0] i_letter,
    input  logic                i_first_of_string,
    input  logic                i_last_of_string,
    output logic                o_valid,
    output t_item               o_item,
    input  logic                i_take
);

    t_item              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push;
    logic               do_pop;
    t_item              item;

    assign full    = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = push & ~full;
    assign do_pop  = i_take & o_valid;

    always_comb begin
        item.letter          = clamp_letter(i_letter);
        item.first_of_string = i_first_of_string;
        item.last_of_string  = i_last_of_string;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr] <= item;
        end
    end

    assign o_item = r_q[r_rd];

endmodule

@@ design/wndc_back.sv @@
// ----------------------------------------------------------------------------
// wndc_back
// Window engine: slides the letter ring, keeps per-letter counts and the
// distinct count, tests full windows and queues one result per letter.
// ----------------------------------------------------------------------------
module wndc_back import wndc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg_ctl               i_ctl,
    input  logic                   i_valid,
    input  t_item                  i_item,
    output logic                   o_take,
    output logic                   empty,
    input  logic                   pop,
    output logic                   o_window_full,
    output logic                   o_window_matches,
    output logic [TOTAL_WIDTH-1:0] o_match_total,
    output logic                   o_string_done
);

    localparam int PW = LEN_W + 1;
    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

    logic [LETTER_W-1:0]    r_ring [WINDOW_MAX];
    logic [PTR_W-1:0]       r_ptr;
    logic [COUNT_W-1:0]     r_cnt  [ALPHABET];
    logic [LEN_W-1:0]       r_distinct;
    logic [LEN_W-1:0]       r_seen;
    logic [TOTAL_WIDTH-1:0] r_total;

    t_result                r_oq [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      r_owr;
    logic [QPTR_W-1:0]      r_ord;
    logic [QCNT_W-1:0]      r_ocnt;

    logic                   first;
    logic [LEN_W-1:0]       k;
    logic [PTR_W-1:0]       ptr_b;
    logic [LEN_W-1:0]       seen_b;
    logic [LEN_W-1:0]       dist_b;
    logic [TOTAL_WIDTH-1:0] total_b;
    logic                   drop;
    logic [PW-1:0]          pos_ext;
    logic [PTR_W-1:0]       pos;
    logic [LETTER_W-1:0]    old;
    logic [COUNT_W-1:0]     n_cnt  [ALPHABET];
    logic [ALPHABET-1:0]    up;
    logic [ALPHABET-1:0]    down;
    logic [LEN_W-1:0]       n_distinct;
    logic [LEN_W-1:0]       n_seen;
    logic [PTR_W-1:0]       n_ptr;
    logic [TOTAL_WIDTH-1:0] n_total;
    t_result                res;
    logic                   space;
    logic                   do_pop;

    assign space  = (r_ocnt != QCNT_W'(QUEUE_DEPTH));
    assign o_take = i_valid & space;
    assign empty  = (r_ocnt == '0);
    assign do_pop = pop & ~empty;

    assign first   = i_item.first_of_string;
    assign k       = i_ctl.window_len;
    assign ptr_b   = first ? '0 : r_ptr;
    assign seen_b  = first ? '0 : r_seen;
    assign dist_b  = first ? '0 : r_distinct;
    assign total_b = first ? '0 : r_total;
    assign drop    = (seen_b >= k);

    // Slot of the letter leaving the window, k places behind the write slot.
    always_comb begin
        if (PW'(ptr_b) >= PW'(k)) begin
            pos_ext = PW'(ptr_b) - PW'(k);
        end else begin
            pos_ext = PW'(ptr_b) + PW'(WINDOW_MAX) - PW'(k);
        end
    end
    assign pos = pos_ext[PTR_W-1:0];
    assign old = r_ring[pos];

    // Per-letter lanes: add the new letter first, then drop the old one.
    always_comb begin
        logic [COUNT_W-1:0] e;
        logic [COUNT_W-1:0] e1;
        logic               inc;
        logic               dec;
        for (int i = 0; i < ALPHABET; i++) begin
            e   = first ? '0 : r_cnt[i];
            inc = (i_item.letter == LETTER_W'(i));
            dec = drop & (old == LETTER_W'(i));
            e1  = e + COUNT_W'(inc);
            up[i]    = inc & (e == '0);
            down[i]  = dec & (e1 == COUNT_W'(1));
            n_cnt[i] = (dec && e1 != '0) ? e1 - 1'b1 : e1;
        end
    end

    always_comb begin
        logic [LEN_W-1:0] d1;
        d1 = dist_b + LEN_W'(|up);
        n_distinct = ((|down) && d1 != '0) ? d1 - 1'b1 : d1;
    end

    assign n_seen = drop ? seen_b : seen_b + 1'b1;
    assign n_ptr  = (ptr_b == PTR_W'(WINDOW_MAX - 1)) ? '0 : ptr_b + 1'b1;

    always_comb begin
        res.window_full    = (n_seen >= k);
        res.window_matches = res.window_full & ((PW'(n_distinct) + PW'(1)) == PW'(k));
        n_total            = (res.window_matches && total_b != TOTAL_MAX) ?
                             total_b + 1'b1 : total_b;
        res.match_total    = n_total;
        res.string_done    = i_item.last_of_string;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_ptr      <= '0;
            r_distinct <= '0;
            r_seen     <= '0;
            r_total    <= '0;
            for (int i = 0; i < ALPHABET; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (o_take) begin
            r_ptr      <= n_ptr;
            r_distinct <= n_distinct;
            r_seen     <= n_seen;
            r_total    <= n_total;
            for (int i = 0; i < ALPHABET; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ring[ptr_b] <= i_item.letter;
        end
    end

    // Result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (o_take) begin
                r_owr <= r_owr + 1'b1;
            end
            if (do_pop) begin
                r_ord <= r_ord + 1'b1;
            end
            if (o_take && !do_pop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (do_pop && !o_take) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_oq[r_owr] <= res;
        end
    end

    assign o_window_full    = r_oq[r_ord].window_full;
    assign o_window_matches = r_oq[r_ord].window_matches;
    assign o_match_total    = r_oq[r_ord].match_total;
    assign o_string_done    = r_oq[r_ord].string_done;

`ifndef SYNTHESIS
    a_distinct_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_distinct <= r_seen)
        else $error("distinct count exceeds letters in window");

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= LEN_W'(WINDOW_MAX))
        else $error("seen count beyond window capacity");

    a_clear_wipes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> (r_seen == '0 && r_total == '0 && r_distinct == '0))
        else $error("length write did not clear string state");

    a_match_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (!o_window_matches || o_window_full))
        else $error("match reported on a window that is not full");
`endif

endmodule

@@ design/window_near_distinct_counter.sv @@
// A letter accepted into the input queue passes to the window engine, which
// writes its result into the result queue that drives the result ports.
// Throughput: one letter per cycle while the result queue has room.
// Reset: synchronous, active low; clears both queues, the window state and
// the running total, and sets window_length to 2. The letter ring is not reset.
// ----------------------------------------------------------------------------
// window_near_distinct_counter
// Counts windows of window_length letters holding window_length - 1 distinct
// letters, per string, with one result per letter.
// ----------------------------------------------------------------------------
module window_near_distinct_counter import wndc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    input  logic                   push,
    output logic                   full,
    input  logic [LETTER_W-1:0]    i_letter,
    input  logic                   i_first_of_string,
    input  logic                   i_last_of_string,
    output logic                   empty,
    input  logic                   pop,
    output logic                   o_window_full,
    output logic                   o_window_matches,
    output logic [TOTAL_WIDTH-1:0] o_match_total,
    output logic                   o_string_done
);

    t_cfg_ctl ctl;
    logic     item_valid;
    t_item    item;
    logic     take;

    wndc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_ctl   (ctl)
    );

    wndc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_letter          (i_letter),
        .i_first_of_string (i_first_of_string),
        .i_last_of_string  (i_last_of_string),
        .o_valid           (item_valid),
        .o_item            (item),
        .i_take            (take)
    );

    wndc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .i_valid          (item_valid),
        .i_item           (item),
        .o_take           (take),
        .empty            (empty),
        .pop              (pop),
        .o_window_full    (o_window_full),
        .o_window_matches (o_window_matches),
        .o_match_total    (o_match_total),
        .o_string_done    (o_string_done)
    );

endmodule
